// ===== src/periodic_timer_bank_top_assert.svh =====
// Assertion macros for the periodic timer bank checker.
`ifndef PERIODIC_TIMER_BANK_TOP_ASSERT_SVH
`define PERIODIC_TIMER_BANK_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PTB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptb: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PTB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptb: next-cycle check failed");

`endif

// ===== src/ptb_pkg.sv =====
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

   localparam int MAX_TIMERS_DEF = 16;
   localparam int TIME_W         = 32;
   localparam int IDX_W          = 4;
   localparam int RESULT_MAX     = 16;
   localparam int RCNT_W         = $clog2(RESULT_MAX + 1);

   typedef enum logic [1:0] {
      EV_ADDED   = 2'd0,
      EV_FULL    = 2'd1,
      EV_EXPIRED = 2'd2,
      EV_NONE    = 2'd3
   } event_type;

   typedef struct packed {
      logic add_go;
      logic tick_go;
      logic step;
      logic flush;
   } ctl_type;

   typedef struct packed {
      logic out_free;
      logic cmd_add;
      logic scan_stall;
      logic scan_end;
   } sts_type;

endpackage
`default_nettype wire

// ===== src/ptb_req_if.sv =====
// Request channel of the periodic timer bank.
`timescale 1ns / 1ps
`default_nettype none
interface ptb_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ptb_pkg::TIME_W-1:0]  elapsed;
   logic [ptb_pkg::TIME_W-1:0]  period;
   logic                        notify;

   modport source (output valid, output cmd, output elapsed, output period, output notify,
                   input ready);
   modport sink   (input valid, input cmd, input elapsed, input period, input notify,
                   output ready);
endinterface
`default_nettype wire

// ===== src/ptb_rsp_if.sv =====
// Response channel of the periodic timer bank.
`timescale 1ns / 1ps
`default_nettype none
interface ptb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 event_res;
   logic [ptb_pkg::IDX_W-1:0]  timer_index;
   logic                       last;

   modport source (output valid, output event_res, output timer_index, output last,
                   input ready);
   modport sink   (input valid, input event_res, input timer_index, input last,
                   output ready);
endinterface
`default_nettype wire

// ===== src/ptb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/ptb_ctrl.sv =====
// Controller state machine: request intake, slot scan sequencing, final response.
`timescale 1ns / 1ps
`default_nettype none
module ptb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptb_pkg::sts_type sts,
   output ptb_pkg::ctl_type      ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      fire;

   assign req_ready = (state_ff == ST_IDLE) && sts.out_free;
   assign fire      = req_valid && req_ready;

   always_comb begin
      ctl         = '0;
      ctl.add_go  = fire && sts.cmd_add;
      ctl.tick_go = fire && !sts.cmd_add;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire && !sts.cmd_add) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               state_in = ST_FLUSH;
            end else if (!sts.scan_stall) begin
               ctl.step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               ctl.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/ptb_dpath.sv =====
// Datapath: timer table RAM, slot counters, pending expiry and response register.
`timescale 1ns / 1ps
`default_nettype none
module ptb_dpath #(
   parameter int MAX_TIMERS = ptb_pkg::MAX_TIMERS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_cmd,
   input  wire logic [ptb_pkg::TIME_W-1:0]  req_elapsed,
   input  wire logic [ptb_pkg::TIME_W-1:0]  req_period,
   input  wire logic                        req_notify,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_event_res,
   output logic [ptb_pkg::IDX_W-1:0]        rsp_timer_index,
   output logic                             rsp_last,
   input  wire ptb_pkg::ctl_type            ctl,
   output ptb_pkg::sts_type                 sts
);

   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int TW = ptb_pkg::TIME_W;
   localparam int WW = 2 * TW + 1;
   localparam int XW = ptb_pkg::IDX_W;
   localparam int RW = ptb_pkg::RCNT_W;

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic                eval_valid_ff, eval_valid_in;
   logic [IW-1:0]       eval_idx_ff, eval_idx_in;
   logic [TW-1:0]       elapsed_ff, elapsed_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [XW-1:0]       pend_idx_ff, pend_idx_in;
   logic [RW-1:0]       rep_cnt_ff, rep_cnt_in;
   logic                out_valid_ff, out_valid_in;
   ptb_pkg::event_type  out_event_ff, out_event_in;
   logic [XW-1:0]       out_index_ff, out_index_in;
   logic                out_last_ff, out_last_in;

   logic                wr_en, rd_en;
   logic [IW-1:0]       wr_addr, rd_addr;
   logic [WW-1:0]       wr_data, rd_data;
   logic [TW-1:0]       cur_remain, cur_reload;
   logic                cur_notify, expire, report, out_free;

   ptb_ram #(.WIDTH(WW), .DEPTH(MAX_TIMERS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // table word: {notify, reload, remaining}
   assign cur_remain = rd_data[TW-1:0];
   assign cur_reload = rd_data[2*TW-1:TW];
   assign cur_notify = rd_data[WW-1];
   assign expire     = cur_remain <= elapsed_ff;
   assign report     = eval_valid_ff && expire && cur_notify &&
                       (rep_cnt_ff < RW'(ptb_pkg::RESULT_MAX));
   assign out_free   = !out_valid_ff || rsp_ready;

   assign sts.out_free   = out_free;
   assign sts.cmd_add    = req_cmd;
   assign sts.scan_stall = report && pend_valid_ff && !out_free;
   assign sts.scan_end   = !eval_valid_ff && (rd_idx_ff == count_ff);

   always_comb begin
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in   = eval_idx_ff;
      elapsed_in    = elapsed_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rep_cnt_in    = rep_cnt_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_event_in  = out_event_ff;
      out_index_in  = out_index_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_data       = {cur_notify, cur_reload, expire ? cur_reload : cur_remain - elapsed_ff};
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[IW-1:0];

      if (ctl.add_go) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b1;
         if (count_ff == CW'(MAX_TIMERS)) begin
            out_event_in = ptb_pkg::EV_FULL;
            out_index_in = '0;
         end else begin
            wr_en        = 1'b1;
            wr_addr      = count_ff[IW-1:0];
            wr_data      = {req_notify, req_period, req_period};
            out_event_in = ptb_pkg::EV_ADDED;
            out_index_in = XW'(count_ff);
            count_in     = count_ff + 1'b1;
         end
      end

      if (ctl.tick_go) begin
         elapsed_in    = req_elapsed;
         rd_idx_in     = '0;
         eval_valid_in = 1'b0;
         pend_valid_in = 1'b0;
         rep_cnt_in    = '0;
      end

      if (ctl.step) begin
         if (eval_valid_ff) begin
            wr_en = 1'b1;
            if (report) begin
               rep_cnt_in    = rep_cnt_ff + 1'b1;
               pend_valid_in = 1'b1;
               pend_idx_in   = XW'(eval_idx_ff);
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_event_in = ptb_pkg::EV_EXPIRED;
                  out_index_in = pend_idx_ff;
                  out_last_in  = 1'b0;
               end
            end
         end
         if (rd_idx_ff != count_ff) begin
            rd_en         = 1'b1;
            rd_idx_in     = rd_idx_ff + 1'b1;
            eval_valid_in = 1'b1;
            eval_idx_in   = rd_idx_ff[IW-1:0];
         end else begin
            eval_valid_in = 1'b0;
         end
      end

      if (ctl.flush) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b1;
         if (pend_valid_ff) begin
            out_event_in = ptb_pkg::EV_EXPIRED;
            out_index_in = pend_idx_ff;
         end else begin
            out_event_in = ptb_pkg::EV_NONE;
            out_index_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         rep_cnt_ff    <= rep_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
      eval_idx_ff  <= eval_idx_in;
      elapsed_ff   <= elapsed_in;
      pend_idx_ff  <= pend_idx_in;
      out_event_ff <= out_event_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = out_event_ff;
   assign rsp_timer_index = out_index_ff;
   assign rsp_last        = out_last_ff;

endmodule
`default_nettype wire

// ===== src/periodic_timer_bank_top.sv =====
// Top level of the periodic timer bank.
//
//   channel   direction  handshake                 payload
//   req_bus   in         req_bus.valid / .ready    cmd, elapsed, period, notify
//   rsp_bus   out        rsp_bus.valid / .ready    event_res, timer_index, last
//
// An add request's response is registered in the cycle after it is accepted.
// A tick request holds the input from its accept through the scan: one slot read
// per cycle while the scan is not held, the registered read of the last slot, the
// end of the scan and the final response. An expiry response that finds the
// output register still full holds the scan while the sink stalls.
// Synchronous reset empties the table and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_bank_top #(
   parameter int MAX_TIMERS = ptb_pkg::MAX_TIMERS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ptb_req_if.sink   req_bus,
   ptb_rsp_if.source rsp_bus
);

   ptb_pkg::ctl_type ctl;
   ptb_pkg::sts_type sts;
   logic             req_ready;

   assign req_bus.ready = req_ready;

   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ptb_dpath #(.MAX_TIMERS(MAX_TIMERS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_bus.cmd),
      .req_elapsed     (req_bus.elapsed),
      .req_period      (req_bus.period),
      .req_notify      (req_bus.notify),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_event_res   (rsp_bus.event_res),
      .rsp_timer_index (rsp_bus.timer_index),
      .rsp_last        (rsp_bus.last),
      .ctl             (ctl),
      .sts             (sts)
   );

endmodule
`default_nettype wire

// ===== src/ptb_checker.sv =====
// Port-level assertion checker for the periodic timer bank, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_timer_bank_top_assert.svh"
module ptb_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_cmd,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [1:0]                 rsp_event_res,
   input wire logic [ptb_pkg::IDX_W-1:0]  rsp_timer_index,
   input wire logic                       rsp_last
);

   logic add_fire, tick_fire, ev_add, ev_full, ev_none;

   assign add_fire  = req_valid && req_ready && req_cmd;
   assign tick_fire = req_valid && req_ready && !req_cmd;
   assign ev_add    = rsp_event_res == ptb_pkg::EV_ADDED;
   assign ev_full   = rsp_event_res == ptb_pkg::EV_FULL;
   assign ev_none   = rsp_event_res == ptb_pkg::EV_NONE;

   `PTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `PTB_ASSERT_NEXT(a_add_reply, add_fire, rsp_valid && rsp_last && (ev_add || ev_full))
   `PTB_ASSERT_NEXT(a_tick_busy, tick_fire, !req_ready)
   `PTB_ASSERT_SAME(a_single_last, rsp_valid && (ev_add || ev_full || ev_none), rsp_last)
   `PTB_ASSERT_SAME(a_zero_index, rsp_valid && (ev_full || ev_none), rsp_timer_index == '0)

endmodule

bind periodic_timer_bank_top ptb_checker u_ptb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_cmd         (req_bus.cmd),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_event_res   (rsp_bus.event_res),
   .rsp_timer_index (rsp_bus.timer_index),
   .rsp_last        (rsp_bus.last)
);
`default_nettype wire
